FILE: design/record_stack_with_search_defines.svh
// ----------------------------------------------------------------------------
// Record stack with search - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RECORD_STACK_WITH_SEARCH_DEFINES_SVH
`define RECORD_STACK_WITH_SEARCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RSWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rsws_pkg.sv
// ----------------------------------------------------------------------------
// rsws_pkg
// Widths, codes and types shared by the record stack with search.
// ----------------------------------------------------------------------------
package rsws_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int ACT_W    = 2;
  localparam int KEY_W    = 16;
  localparam int REC_W    = 64;
  localparam int STAT_W   = 2;
  localparam int OUT_CW   = 5;   // found_position / fill_level width

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } cmd_t;

  // Truncate an entry count to the 5-bit result fields.
  function automatic logic [OUT_CW-1:0] to_out_cnt(input logic [CNT_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[OUT_CW-1:0];
  endfunction

endpackage

FILE: design/rsws_if.sv
// ----------------------------------------------------------------------------
// rsws channel interfaces
// Valid/ready channels for stack actions and their results.
// ----------------------------------------------------------------------------
interface rsws_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsws_pkg::ACT_W-1:0]  action;
  logic [rsws_pkg::KEY_W-1:0]  entry_key;
  logic [rsws_pkg::REC_W-1:0]  entry_record;

  modport source (output valid, action, entry_key, entry_record, input ready);
  modport sink   (input valid, action, entry_key, entry_record, output ready);
endinterface

interface rsws_out_if;
  logic                         valid;
  logic                         ready;
  logic [rsws_pkg::STAT_W-1:0]  status;
  logic [rsws_pkg::OUT_CW-1:0]  found_position;
  logic [rsws_pkg::KEY_W-1:0]   out_key;
  logic [rsws_pkg::REC_W-1:0]   out_record;
  logic [rsws_pkg::OUT_CW-1:0]  fill_level;

  modport source (output valid, status, found_position, out_key, out_record, fill_level,
                  input ready);
  modport sink   (input valid, status, found_position, out_key, out_record, fill_level,
                  output ready);
endinterface

FILE: design/rsws_front.sv
// ----------------------------------------------------------------------------
// rsws_front
// Takes action transfers and decodes them into commands for the queue.
// ----------------------------------------------------------------------------
module rsws_front (
  rsws_in_if.sink          in_chan,
  output logic             q_wr,
  output rsws_pkg::cmd_t   q_wdata,
  input  logic             q_full
);
  import rsws_pkg::*;

  assign in_chan.ready = !q_full;
  assign q_wr          = in_chan.valid && !q_full;

  always_comb begin
    case (in_chan.action)
      ACT_PUSH:   q_wdata.op = OP_PUSH;
      ACT_POP:    q_wdata.op = OP_POP;
      ACT_SEARCH: q_wdata.op = OP_SEARCH;
      default:    q_wdata.op = OP_NOP;
    endcase
    q_wdata.key = in_chan.entry_key;
    q_wdata.rec = in_chan.entry_record;
  end

endmodule

FILE: design/rsws_queue.sv
// ----------------------------------------------------------------------------
// rsws_queue
// Short command FIFO between the front end and the execution unit.
// ----------------------------------------------------------------------------
module rsws_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  rsws_pkg::cmd_t  wdata,
  output logic            full,
  input  logic            rd,
  output rsws_pkg::cmd_t  rdata,
  output logic            nonempty
);
  import rsws_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (rd) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/rsws_back.sv
// ----------------------------------------------------------------------------
// rsws_back
// Execution unit: entry memories, entry count, search walk, result register.
// ----------------------------------------------------------------------------
`include "record_stack_with_search_defines.svh"

module rsws_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  rsws_pkg::cmd_t  q_rdata,
  output logic            q_rd,
  rsws_out_if.source      out_chan
);
  import rsws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  logic [KEY_W-1:0] key_mem [STACK_DEPTH];
  logic [REC_W-1:0] rec_mem [STACK_DEPTH];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  idx_r, idx_nxt;    // address whose data sits in rd_*_r
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [KEY_W-1:0]  skey_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [REC_W-1:0]  rd_rec_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r;
  logic [OUT_CW-1:0] pos_out_r;
  logic [KEY_W-1:0]  key_out_r;
  logic [REC_W-1:0]  rec_out_r;
  logic [OUT_CW-1:0] fill_r;

  logic              slot_free;
  logic              is_full;
  logic              wr_en;
  logic              start_search;
  logic              load;
  logic [STAT_W-1:0] res_status;
  logic [CNT_W-1:0]  res_pos;
  logic [KEY_W-1:0]  res_key;
  logic [REC_W-1:0]  res_rec;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign is_full   = (count_r == CNT_W'(STACK_DEPTH));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    q_rd         = 1'b0;
    wr_en        = 1'b0;
    start_search = 1'b0;
    load         = 1'b0;
    res_status   = ST_OK;
    res_pos      = '0;
    res_key      = '0;
    res_rec      = '0;
    case (state_r)
      S_IDLE: begin
        // read the top entry ahead of time; pop and search both start there
        idx_nxt = PTR_W'(count_r - CNT_W'(1));
        if (q_valid && slot_free) begin
          q_rd = 1'b1;
          case (q_rdata.op)
            OP_PUSH: begin
              load = 1'b1;
              if (is_full) begin
                res_status = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                load       = 1'b1;
                res_status = ST_UNDERFLOW;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_POP;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                load       = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                start_search = 1'b1;
                pos_nxt      = CNT_W'(1);
                state_nxt    = S_SRCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          load      = 1'b1;
          res_key   = rd_key_r;
          res_rec   = rd_rec_r;
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        if (rd_key_r == skey_r) begin
          if (slot_free) begin
            load      = 1'b1;
            res_pos   = pos_r;
            res_key   = rd_key_r;
            res_rec   = rd_rec_r;
            state_nxt = S_IDLE;
          end
        end else if (pos_r == count_r) begin
          if (slot_free) begin
            load       = 1'b1;
            res_status = ST_NOT_FOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r - PTR_W'(1);
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // entry memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[count_r[PTR_W-1:0]] <= q_rdata.key;
      rec_mem[count_r[PTR_W-1:0]] <= q_rdata.rec;
    end
    rd_key_r <= key_mem[idx_nxt];
    rd_rec_r <= rec_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (start_search) begin
      skey_r <= q_rdata.key;
    end
    if (load) begin
      status_r  <= res_status;
      pos_out_r <= to_out_cnt(res_pos);
      key_out_r <= res_key;
      rec_out_r <= res_rec;
      fill_r    <= to_out_cnt(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.found_position = pos_out_r;
  assign out_chan.out_key        = key_out_r;
  assign out_chan.out_record     = rec_out_r;
  assign out_chan.fill_level     = fill_r;

  `RSWS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(STACK_DEPTH), "entry count above depth")
  `RSWS_ASSERT_SAME(a_walk_index, state_r == S_SRCH, (CNT_W'(idx_r) + pos_r) == count_r, "search index and position disagree")
  `RSWS_ASSERT_NEXT(a_push_grows, wr_en, count_r == ($past(count_r) + CNT_W'(1)), "push did not grow the stack")
  `RSWS_ASSERT_SAME(a_no_result_overwrite, load, slot_free, "pending result overwritten")

endmodule

FILE: design/record_stack_with_search.sv
// ----------------------------------------------------------------------------
// record_stack_with_search
// LIFO of 16-bit keys with 64-bit records: push, pop and search by key.
// ----------------------------------------------------------------------------
// One result transfer per action transfer, in order. A two-entry command queue
// lets actions be taken while the execution unit is busy or a result is
// pending. In the execution unit, push, an action with code 3, underflow,
// overflow and a search of an empty stack load their result from the idle
// state; pop loads it from the pop state, after reading the top entry; a
// search walks from the top and stops at position p (hit at p, or miss at p
// equal to the fill level). The search rate is set by the single registered
// read port of the entry memories, one entry per cycle walked from the top.
// No clearing pass after reset: only entries below the fill level are used.
module record_stack_with_search (
  input  logic   clk,
  input  logic   rst_n,
  rsws_in_if.sink     in_chan,
  rsws_out_if.source  out_chan
);
  import rsws_pkg::*;

  logic  q_wr;
  logic  q_full;
  logic  q_rd;
  logic  q_nonempty;
  cmd_t  q_wdata;
  cmd_t  q_rdata;

  rsws_front u_front (
    .in_chan (in_chan),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  rsws_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd       (q_rd),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  rsws_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_nonempty),
    .q_rdata  (q_rdata),
    .q_rd     (q_rd),
    .out_chan (out_chan)
  );

endmodule
